// File: rtl/vec3_normalize_defines.svh
// Assertion macros shared by the vector normalizer RTL.
`ifndef VEC3_NORMALIZE_DEFINES_SVH
`define VEC3_NORMALIZE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vec3_normalize: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vec3_normalize: next-cycle check failed");

`endif

// File: rtl/vn_pkg.sv
`default_nettype none
package vn_pkg;

  // Default component width, signed Q8.8.
  localparam int COMPONENT_BITS_DEF = 16;
  // Fraction bits of the result and quotient width (covers 0..16384).
  localparam int FRAC_BITS = 14;
  localparam int QW = FRAC_BITS + 1;
  localparam int OUT_W = 16;
  localparam logic [QW-1:0] UNIT_MAX = QW'(1 << FRAC_BITS);

  // Saturate a quotient, give it the component's sign, and force zero vectors to zero.
  function automatic logic [OUT_W-1:0] vn_finish(logic [QW-1:0] q, logic neg, logic zero);
    logic [QW-1:0] sat;
    logic [OUT_W-1:0] mag;
    sat = (q > UNIT_MAX) ? UNIT_MAX : q;
    mag = OUT_W'(sat);
    if (zero) begin
      return '0;
    end
    return neg ? (~mag + OUT_W'(1)) : mag;
  endfunction

endpackage
`default_nettype wire

// File: rtl/vn_sqrt_cell.sv
`default_nettype none
module vn_sqrt_cell #(
  parameter int CB = 16
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*CB-1:0] rad_in,
  input  wire logic [CB:0]     rem_in,
  input  wire logic [CB-1:0]   root_in,
  output logic      [2*CB-1:0] rad_out,
  output logic      [CB:0]     rem_out,
  output logic      [CB-1:0]   root_out
);

  logic [CB+2:0] trial_rem;
  logic [CB+2:0] trial;
  logic [CB+2:0] diff;
  logic          take;

  // One root bit per cell: bring down two radicand bits and try 4*root+1.
  always_comb begin
    trial_rem = {rem_in, rad_in[2*CB-1 -: 2]};
    trial     = {1'b0, root_in, 2'b01};
    diff      = trial_rem - trial;
    take      = (trial_rem >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= {rad_in[2*CB-3:0], 2'b00};
      if (take) begin
        rem_out  <= diff[CB:0];
        root_out <= {root_in[CB-2:0], 1'b1};
      end else begin
        rem_out  <= trial_rem[CB:0];
        root_out <= {root_in[CB-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/vn_div_cell.sv
`default_nettype none
module vn_div_cell #(
  parameter int CB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [CB-1:0]        rem_in,
  input  wire logic                 bit_in,
  input  wire logic [CB-1:0]        len,
  input  wire logic [vn_pkg::QW-1:0] q_in,
  output logic      [CB-1:0]        rem_out,
  output logic      [vn_pkg::QW-1:0] q_out
);
  import vn_pkg::*;

  logic [CB:0] trial;
  logic [CB:0] diff;
  logic        take;

  // Restoring division step: one quotient bit per cell.
  always_comb begin
    trial = {rem_in, bit_in};
    diff  = trial - {1'b0, len};
    take  = (trial >= {1'b0, len});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? diff[CB-1:0] : trial[CB-1:0];
      q_out   <= {q_in[QW-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: rtl/vec3_normalize.sv
// Throughput: one item per cycle while out_stall is low; the square-root and divider
// cell chains are fully pipelined. Each stage holds its item while stalled and bubbles
// are squeezed out, so input is taken whenever any stage is empty or out_stall is low.
// Reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none
`include "vec3_normalize_defines.svh"
module vec3_normalize #(
  parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [COMPONENT_BITS-1:0]  comp_x,
  input  wire logic signed [COMPONENT_BITS-1:0]  comp_y,
  input  wire logic signed [COMPONENT_BITS-1:0]  comp_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [vn_pkg::OUT_W-1:0]        unit_x,
  output logic signed [vn_pkg::OUT_W-1:0]        unit_y,
  output logic signed [vn_pkg::OUT_W-1:0]        unit_z,
  output logic                                   zero_length
);
  import vn_pkg::*;

  localparam int CB    = COMPONENT_BITS;
  localparam int SW    = 2 * CB;
  localparam int S_SQ0 = 3;
  localparam int S_DV0 = S_SQ0 + CB;
  localparam int S_OUT = S_DV0 + QW;
  localparam int NST   = S_OUT + 1;

  logic [NST-1:0] v;
  logic [NST-1:0] rdy;
  logic [NST-1:0] prev_v;

  // Stage handshake: a stage loads when it is empty or its item moves on.
  assign prev_v = {v[NST-2:0], in_valid};
  assign rdy[NST-1] = !v[NST-1] || !out_stall;
  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~rdy) | (prev_v & rdy);
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[NST-1];

  // Input stage: split each component into sign and magnitude.
  logic [CB-1:0] mag0 [3];
  logic [2:0]    neg0;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mag0[0] <= comp_x[CB-1] ? (~comp_x + CB'(1)) : comp_x;
      mag0[1] <= comp_y[CB-1] ? (~comp_y + CB'(1)) : comp_y;
      mag0[2] <= comp_z[CB-1] ? (~comp_z + CB'(1)) : comp_z;
      neg0    <= {comp_z[CB-1], comp_y[CB-1], comp_x[CB-1]};
    end
  end

  // Square each magnitude.
  logic [SW-1:0] sq1 [3];
  logic [CB-1:0] mag1 [3];
  logic [2:0]    neg1;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq1[i]  <= SW'(mag0[i]) * SW'(mag0[i]);
        mag1[i] <= mag0[i];
      end
      neg1 <= neg0;
    end
  end

  // Sum of squares, exact in 2*CB bits.
  logic [SW-1:0] sum2;
  logic [CB-1:0] mag2 [3];
  logic [2:0]    neg2;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sum2 <= sq1[0] + sq1[1] + sq1[2];
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  // Square-root chain: one cell per root bit, magnitudes and signs ride alongside.
  logic [SW-1:0] rad_c  [CB];
  logic [CB:0]   rem_c  [CB];
  logic [CB-1:0] root_c [CB];
  logic [CB-1:0] mag_c  [CB][3];
  logic [2:0]    neg_c  [CB];

  generate
    for (k = 0; k < CB; k++) begin : g_sqrt
      logic [SW-1:0] rad_i;
      logic [CB:0]   rem_i;
      logic [CB-1:0] root_i;
      if (k == 0) begin : g_first
        assign rad_i  = sum2;
        assign rem_i  = '0;
        assign root_i = '0;
        always_ff @(posedge clk) begin
          if (rdy[S_SQ0+k]) begin
            mag_c[k] <= mag2;
            neg_c[k] <= neg2;
          end
        end
      end else begin : g_next
        assign rad_i  = rad_c[k-1];
        assign rem_i  = rem_c[k-1];
        assign root_i = root_c[k-1];
        always_ff @(posedge clk) begin
          if (rdy[S_SQ0+k]) begin
            mag_c[k] <= mag_c[k-1];
            neg_c[k] <= neg_c[k-1];
          end
        end
      end
      vn_sqrt_cell #(.CB(CB)) u_sqrt (
        .clk      (clk),
        .en       (rdy[S_SQ0+k]),
        .rad_in   (rad_i),
        .rem_in   (rem_i),
        .root_in  (root_i),
        .rad_out  (rad_c[k]),
        .rem_out  (rem_c[k]),
        .root_out (root_c[k])
      );
    end
  endgenerate

  // Divider chains: three lanes, one quotient bit per cell, length and signs alongside.
  logic [CB-1:0] drem_d [QW][3];
  logic [QW-1:0] q_d    [QW][3];
  logic [CB-1:0] len_d  [QW];
  logic [2:0]    neg_d  [QW];

  genvar l;
  generate
    for (k = 0; k < QW; k++) begin : g_div
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (rdy[S_DV0+k]) begin
            len_d[k] <= root_c[CB-1];
            neg_d[k] <= neg_c[CB-1];
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (rdy[S_DV0+k]) begin
            len_d[k] <= len_d[k-1];
            neg_d[k] <= neg_d[k-1];
          end
        end
      end
      for (l = 0; l < 3; l++) begin : g_lane
        logic [CB-1:0] rem_i;
        logic          bit_i;
        logic [CB-1:0] len_i;
        logic [QW-1:0] q_i;
        if (k == 0) begin : g_first
          // Magnitude never exceeds the length, so the top quotient bits are zero.
          assign rem_i = {1'b0, mag_c[CB-1][l][CB-1:1]};
          assign bit_i = mag_c[CB-1][l][0];
          assign len_i = root_c[CB-1];
          assign q_i   = '0;
        end else begin : g_next
          assign rem_i = drem_d[k-1][l];
          assign bit_i = 1'b0;
          assign len_i = len_d[k-1];
          assign q_i   = q_d[k-1][l];
        end
        vn_div_cell #(.CB(CB)) u_div (
          .clk     (clk),
          .en      (rdy[S_DV0+k]),
          .rem_in  (rem_i),
          .bit_in  (bit_i),
          .len     (len_i),
          .q_in    (q_i),
          .rem_out (drem_d[k][l]),
          .q_out   (q_d[k][l])
        );
      end
    end
  endgenerate

  // Output register: saturate, apply signs, flag a zero-length vector.
  logic zero_last;
  assign zero_last = (len_d[QW-1] == '0);
  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      unit_x      <= vn_finish(q_d[QW-1][0], neg_d[QW-1][0], zero_last);
      unit_y      <= vn_finish(q_d[QW-1][1], neg_d[QW-1][1], zero_last);
      unit_z      <= vn_finish(q_d[QW-1][2], neg_d[QW-1][2], zero_last);
      zero_length <= zero_last;
    end
  end

  // A zero-length item carries all-zero components.
  `VN_ASSERT_IMP(a_zero_out, out_valid && zero_length,
                 unit_x == '0 && unit_y == '0 && unit_z == '0)
  // Every result stays within plus or minus one in Q1.14.
  `VN_ASSERT_IMP(a_range, out_valid,
                 unit_x <= 16384 && unit_x >= -16384 &&
                 unit_y <= 16384 && unit_y >= -16384 &&
                 unit_z <= 16384 && unit_z >= -16384)
  // An accepted item lands in the first stage.
  `VN_ASSERT_NXT(a_land, in_valid && !in_stall, v[0])
  // An empty first stage never stalls the input.
  `VN_ASSERT_IMP(a_no_false_stall, !v[0], !in_stall)

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import vn_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int LATENCY = CB + 18;
  localparam int RANDOM_ITEMS = 470;

  // One normalized result.
  typedef struct packed {
    logic [OUT_W-1:0] ux;
    logic [OUT_W-1:0] uy;
    logic [OUT_W-1:0] uz;
    logic zl;
  } unit_vec_t;

  // One row of directed stimulus; has_known says the expected value is typed in.
  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    bit has_known;
    unit_vec_t known;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] comp_x = '0;
  logic signed [CB-1:0] comp_y = '0;
  logic signed [CB-1:0] comp_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] unit_x;
  logic signed [OUT_W-1:0] unit_y;
  logic signed [OUT_W-1:0] unit_z;
  logic zero_length;

  unit_vec_t pending_units[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int zero_seen = 0;
  int sat_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  vec3_normalize #(.COMPONENT_BITS(CB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .zero_length(zero_length)
  );

  always #5 clk = ~clk;

  // Floor square root, bit by bit.
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Unit vector of one input vector in signed Q1.14.
  function automatic unit_vec_t normalize_vec(logic [CB-1:0] x, logic [CB-1:0] y,
                                               logic [CB-1:0] z);
    logic [CB-1:0] c[3];
    longint unsigned mag[3];
    bit neg[3];
    longint unsigned sumsq;
    longint unsigned len;
    longint unsigned q;
    logic [OUT_W-1:0] r[3];
    unit_vec_t u;
    c[0] = x; c[1] = y; c[2] = z;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][CB-1];
      mag[i] = neg[i] ? ((64'd1 << CB) - longint'(c[i])) : longint'(c[i]);
      sumsq += mag[i] * mag[i];
    end
    len = isqrt(sumsq);
    if (len == 0) begin
      u = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
      return u;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 14) / len;
      if (q > 16384) q = 16384;
      r[i] = neg[i] ? OUT_W'(-q) : OUT_W'(q);
    end
    u = '{ux: r[0], uy: r[1], uz: r[2], zl: 1'b0};
    return u;
  endfunction

  // Offer one item and hold it until accepted; valid stays high for the next call.
  task automatic send_vec(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                          bit has_known, unit_vec_t known);
    unit_vec_t exp_u;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    exp_u = normalize_vec(x, y, z);
    if (has_known && exp_u !== known) begin
      $display("%0t: predictor disagrees on directed row: expected %h actual %h",
               $time, known, exp_u);
      errors++;
    end
    comp_x <= x; comp_y <= y; comp_z <= z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_units.push_back(exp_u);
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stall pattern.
  always @(negedge clk) begin
    out_stall <= hold_recv || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    unit_vec_t got;
    unit_vec_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{ux: unit_x, uy: unit_y, uz: unit_z, zl: zero_length};
      results_seen++;
      if (zero_length) zero_seen++;
      if (unit_x == 16384 || unit_x == -16384) sat_seen++;
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_units.pop_front();
        if (got.ux !== want.ux)
          $display("%0t: unit_x expected %h actual %h", $time, want.ux, got.ux);
        if (got.uy !== want.uy)
          $display("%0t: unit_y expected %h actual %h", $time, want.uy, got.uy);
        if (got.uz !== want.uz)
          $display("%0t: unit_z expected %h actual %h", $time, want.uz, got.uz);
        if (got.zl !== want.zl)
          $display("%0t: zero_length expected %b actual %b", $time, want.zl, got.zl);
        if (got !== want) errors++;
      end
    end
  end

  // Overall time limit.
  initial begin
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Random component: mostly small or full range, sometimes an extreme.
  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(4))
      0: return CB'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      2: return CB'($signed($urandom_range(512)) - 256);
      default: return CB'($urandom);
    endcase
  endfunction

  initial begin
    vec_row_t rows[$];
    unit_vec_t none;
    unit_vec_t zero_u;
    logic [CB-1:0] mn;
    logic [CB-1:0] mx;
    mn = {1'b1, {(CB-1){1'b0}}};
    mx = {1'b0, {(CB-1){1'b1}}};
    none = '0;
    zero_u = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
    // Directed rows: zero vector, axis vectors, extremes, mixed signs.
    rows.push_back('{'0, '0, '0, 1, zero_u});
    rows.push_back('{16'sd256, '0, '0, 1, '{16'd16384, 16'd0, 16'd0, 1'b0}});
    rows.push_back('{'0, -16'sd256, '0, 1, '{16'd0, -16'sd16384, 16'd0, 1'b0}});
    rows.push_back('{'0, '0, 16'sd1, 1, '{16'd0, 16'd0, 16'd16384, 1'b0}});
    rows.push_back('{mn, '0, '0, 1, '{-16'sd16384, 16'd0, 16'd0, 1'b0}});
    rows.push_back('{'0, mx, '0, 1, '{16'd0, 16'd16384, 16'd0, 1'b0}});
    rows.push_back('{'0, '0, mn, 1, '{16'd0, 16'd0, -16'sd16384, 1'b0}});
    rows.push_back('{mn, mn, mn, 0, none});
    rows.push_back('{mx, mx, mx, 0, none});
    rows.push_back('{mx, mn, mx, 0, none});
    rows.push_back('{16'sd1, 16'sd1, 16'sd1, 0, none});
    rows.push_back('{16'sd1, 16'sd1, '0, 0, none});
    rows.push_back('{-16'sd1, 16'sd1, -16'sd1, 0, none});
    rows.push_back('{16'sd3, 16'sd4, '0, 0, none});
    rows.push_back('{16'sd2, 16'sd2, 16'sd1, 0, none});
    rows.push_back('{16'h5555, 16'hAAAA, 16'h0F0F, 0, none});
    rows.push_back('{16'hAAAA, 16'h5555, 16'hF0F0, 0, none});
    rows.push_back('{16'sd100, -16'sd7, 16'sd3, 0, none});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].has_known,
                               rows[i].known);
    in_valid <= 1'b0;
    // Pause until everything has drained.
    while (pending_units.size() != 0) @(negedge clk);

    // Long receiver hold-off while items keep coming, so the pipeline backs up.
    fork
      begin
        hold_recv = 1'b1;
        repeat (3 * LATENCY) @(negedge clk);
        hold_recv = 1'b0;
      end
      begin
        repeat (60) send_vec(rand_comp(), rand_comp(), rand_comp(), 0, none);
        in_valid <= 1'b0;
      end
    join
    @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 81; recv_idle_pct = 13;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (n == 0) begin
        send_idle_pct = 13; recv_idle_pct = 81;
      end
      send_vec(rand_comp(), rand_comp(), rand_comp(), 0, none);
    end
    in_valid <= 1'b0;

    while (pending_units.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    $display("Sent %0d vectors, checked %0d results (%0d zero, %0d saturated x).",
             items_sent, results_seen, zero_seen, sat_seen);
    $display("Covered extremes, zero vectors, backpressure and both idling mixes.");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/vn_pkg.sv
rtl/vn_sqrt_cell.sv
rtl/vn_div_cell.sv
rtl/vec3_normalize.sv
tb/testbench.sv
